### rtl/core/lfs_pkg.sv
// ----------------------------------------------------------------------------
// lfs_pkg
// Shared constants for the Laplacian flux stencil.
// ----------------------------------------------------------------------------
`default_nettype none

package lfs_pkg;

   localparam int SAMPLE_WIDTH_DEF = 32;
   localparam int PORT_SAMPLE_WIDTH = 32;
   localparam int FLUX_WIDTH = 32;
   localparam int NUM_ROWS = 5;
   localparam int NUM_COLS = 5;
   localparam int NUM_FLUX = 4;
   localparam int FILL_WIDTH = 3;
   localparam logic [FILL_WIDTH-1:0] FILL_FULL = 3'd4;
   // wide enough to hold any Laplacian before it is clamped
   localparam int SAT_WIDTH = 36;
   localparam logic signed [SAT_WIDTH-1:0] FLUX_MAX = 36'sh0_7FFF_FFFF;
   localparam logic signed [SAT_WIDTH-1:0] FLUX_MIN = -36'sh0_8000_0000;

endpackage

`default_nettype wire

### rtl/core/laplacian_flux_stencil.sv
// ----------------------------------------------------------------------------
// laplacian_flux_stencil
// Five-point Laplacian flux differences over a streamed 5x5 column window.
// ----------------------------------------------------------------------------
// One transaction per clock is accepted and one result per clock is given
// once the window holds five columns of the current run, as long as rsp_tready
// holds no result back. An accepted column is shifted into the window
// register; from it the five saturated Laplacians and the four flux
// differences are formed and registered in the result register, so a result
// shows on rsp_tvalid once it is loaded there, later while an earlier result
// is held by backpressure. The window register and the result register are
// each one stage deep, and backpressure on the result side stalls the input
// side only when both hold an item. A column with first_column set restarts
// the run: the first four columns of a run give no result.
`default_nettype none

module laplacian_flux_stencil #(
   parameter int SAMPLE_WIDTH = lfs_pkg::SAMPLE_WIDTH_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // north2_sample, north1_sample, centre_sample, south1_sample, south2_sample
   input  wire logic [159:0] req_tdata,
   // first_column
   input  wire logic         req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // flux_west, flux_east, flux_north, flux_south
   output logic [127:0]      rsp_tdata
);

   localparam int LAP_WIDTH = SAMPLE_WIDTH + 3;
   localparam int PW = lfs_pkg::PORT_SAMPLE_WIDTH;
   localparam int FW = lfs_pkg::FLUX_WIDTH;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic signed [FW-1:0] flux_type;

   sample_type win_ff [lfs_pkg::NUM_ROWS][lfs_pkg::NUM_COLS];
   logic [lfs_pkg::FILL_WIDTH-1:0] fill_ff, fill_in, fill_base;
   logic a_valid_ff, a_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   flux_type flux_ff [lfs_pkg::NUM_FLUX];
   flux_type flux_in [lfs_pkg::NUM_FLUX];
   flux_type lap_c, lap_w, lap_e, lap_n, lap_s;
   logic req_accept, b_load, pend;

   function automatic flux_type lap_sat(input sample_type p, input sample_type a,
                                        input sample_type b, input sample_type c,
                                        input sample_type d);
      logic signed [LAP_WIDTH-1:0] r;
      logic signed [lfs_pkg::SAT_WIDTH-1:0] rx;
      r = (LAP_WIDTH'(p) <<< 2) - LAP_WIDTH'(a) - LAP_WIDTH'(b)
          - LAP_WIDTH'(c) - LAP_WIDTH'(d);
      rx = lfs_pkg::SAT_WIDTH'(r);
      if (rx > lfs_pkg::FLUX_MAX) begin
         rx = lfs_pkg::FLUX_MAX;
      end else if (rx < lfs_pkg::FLUX_MIN) begin
         rx = lfs_pkg::FLUX_MIN;
      end
      return FW'(rx);
   endfunction

   assign b_load     = a_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !a_valid_ff || b_load;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      fill_base = req_tuser ? '0 : fill_ff;
      pend      = (fill_base == lfs_pkg::FILL_FULL);
      fill_in   = fill_ff;
      if (req_accept) begin
         fill_in = pend ? lfs_pkg::FILL_FULL : fill_base + 1'b1;
      end
   end

   always_comb begin
      a_valid_in = a_valid_ff;
      if (req_accept) begin
         a_valid_in = pend;
      end else if (b_load) begin
         a_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (b_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // window is win_ff[row][col], col 4 newest, centre at [2][2]
   always_comb begin
      lap_c = lap_sat(win_ff[2][2], win_ff[2][1], win_ff[2][3], win_ff[1][2], win_ff[3][2]);
      lap_w = lap_sat(win_ff[2][1], win_ff[2][0], win_ff[2][2], win_ff[1][1], win_ff[3][1]);
      lap_e = lap_sat(win_ff[2][3], win_ff[2][2], win_ff[2][4], win_ff[1][3], win_ff[3][3]);
      lap_n = lap_sat(win_ff[1][2], win_ff[0][2], win_ff[2][2], win_ff[1][1], win_ff[1][3]);
      lap_s = lap_sat(win_ff[3][2], win_ff[2][2], win_ff[4][2], win_ff[3][1], win_ff[3][3]);
      flux_in[0] = lap_c - lap_w;
      flux_in[1] = lap_e - lap_c;
      flux_in[2] = lap_c - lap_n;
      flux_in[3] = lap_s - lap_c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         for (int r = 0; r < lfs_pkg::NUM_ROWS; r++) begin
            for (int c = 0; c < lfs_pkg::NUM_COLS - 1; c++) begin
               win_ff[r][c] <= win_ff[r][c+1];
            end
            win_ff[r][lfs_pkg::NUM_COLS-1] <= sample_type'(req_tdata[r*PW +: SAMPLE_WIDTH]);
         end
      end
      if (b_load) begin
         for (int f = 0; f < lfs_pkg::NUM_FLUX; f++) begin
            flux_ff[f] <= flux_in[f];
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {flux_ff[3], flux_ff[2], flux_ff[1], flux_ff[0]};

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= lfs_pkg::FILL_FULL)
      else $error("fill count beyond full window");

   a_pending_full: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff |-> fill_ff == lfs_pkg::FILL_FULL)
      else $error("pending item without a full window");

   a_restart_silent: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_tuser |=> !a_valid_ff)
      else $error("restart column produced a result");

   a_pending_held: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && !b_load |=> a_valid_ff)
      else $error("pending item dropped");

endmodule

`default_nettype wire

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stream test of laplacian_flux_stencil. Columns are driven on the req_
// stream, and each accepted column updates a local copy of the 5x5 window.
// Once the window is full, that copy gives the expected flux result. Each
// rsp_ transaction is checked field by field against the oldest pending
// result. The run covers directed fill, restart and saturation cases, then
// random row bands under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 20;

   typedef logic [lfs_pkg::NUM_ROWS-1:0][lfs_pkg::PORT_SAMPLE_WIDTH-1:0] column_type;
   typedef logic [lfs_pkg::NUM_FLUX-1:0][lfs_pkg::FLUX_WIDTH-1:0] flux_type;

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic           req_tvalid = 1'b0;
   logic           req_tready;
   logic [159:0]   req_tdata = '0;
   logic           req_tuser = 1'b0;
   logic           rsp_tvalid;
   logic           rsp_tready = 1'b0;
   logic [127:0]   rsp_tdata;

   int             send_idle_pct = 0;
   int             rsp_stall_pct = 0;
   int             error_count = 0;
   int             cycle_count = 0;

   column_type     band_window [lfs_pkg::NUM_COLS-1];
   logic [2:0]     band_fill;
   flux_type       pending_flux_q [$];
   string          flux_names [lfs_pkg::NUM_FLUX] = '{"flux_west", "flux_east",
                                                      "flux_north", "flux_south"};

   laplacian_flux_stencil i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results pending", $time, pending_flux_q.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // result checker
   always @(posedge clock) begin
      flux_type got;
      flux_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_flux_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            error_count++;
         end else begin
            want = pending_flux_q.pop_front();
            for (int i = 0; i < lfs_pkg::NUM_FLUX; i++) begin
               if (got[i] !== want[i]) begin
                  $display("%0t: %s mismatch, expected %h, actual %h",
                           $time, flux_names[i], want[i], got[i]);
                  error_count++;
               end
            end
         end
      end
   end

   function automatic logic [lfs_pkg::FLUX_WIDTH-1:0] clamped_laplacian(longint p,
                                                                        longint a,
                                                                        longint b,
                                                                        longint c,
                                                                        longint d);
      longint r;
      r = 4 * p - a - b - c - d;
      if (r > 64'sd2147483647)
         r = 64'sd2147483647;
      if (r < -64'sd2147483648)
         r = -64'sd2147483648;
      return r[lfs_pkg::FLUX_WIDTH-1:0];
   endfunction

   task automatic update_window(input bit first, input column_type col);
      longint g [lfs_pkg::NUM_ROWS][lfs_pkg::NUM_COLS];
      logic [lfs_pkg::FLUX_WIDTH-1:0] lc, lw, le, ln, ls;
      flux_type f;
      if (first)
         band_fill = '0;
      for (int c = 0; c < lfs_pkg::NUM_COLS - 1; c++)
         for (int r = 0; r < lfs_pkg::NUM_ROWS; r++)
            g[r][c] = $signed(band_window[c][r]);
      for (int r = 0; r < lfs_pkg::NUM_ROWS; r++)
         g[r][lfs_pkg::NUM_COLS-1] = $signed(col[r]);
      if (band_fill == lfs_pkg::FILL_FULL) begin
         lc = clamped_laplacian(g[2][2], g[2][1], g[2][3], g[1][2], g[3][2]);
         lw = clamped_laplacian(g[2][1], g[2][0], g[2][2], g[1][1], g[3][1]);
         le = clamped_laplacian(g[2][3], g[2][2], g[2][4], g[1][3], g[3][3]);
         ln = clamped_laplacian(g[1][2], g[0][2], g[2][2], g[1][1], g[1][3]);
         ls = clamped_laplacian(g[3][2], g[2][2], g[4][2], g[3][1], g[3][3]);
         f[0] = lc - lw;
         f[1] = le - lc;
         f[2] = lc - ln;
         f[3] = ls - lc;
         pending_flux_q.push_back(f);
      end
      for (int c = 0; c < lfs_pkg::NUM_COLS - 2; c++)
         band_window[c] = band_window[c+1];
      band_window[lfs_pkg::NUM_COLS-2] = col;
      if (band_fill < lfs_pkg::FILL_FULL)
         band_fill++;
   endtask

   // called and returns at a falling edge
   task automatic send_column(input bit first, input column_type col);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= col;
      req_tuser  <= first;
      forever begin
         @(posedge clock);
         if (req_tready)
            break;
         @(negedge clock);
      end
      update_window(first, col);
      @(negedge clock);
   endtask

   function automatic logic [31:0] random_sample();
      int v;
      case ($urandom_range(5))
         0, 1: return $urandom;
         2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         3: begin
            v = int'($urandom_range(16)) - 8;
            return v;
         end
         4: return 32'h7FFF_FFFF - $urandom_range(255);
         default: return 32'h8000_0000 + $urandom_range(255);
      endcase
   endfunction

   function automatic column_type random_column();
      column_type col;
      for (int r = 0; r < lfs_pkg::NUM_ROWS; r++)
         col[r] = random_sample();
      return col;
   endfunction

   task automatic apply_reset();
      for (int c = 0; c < lfs_pkg::NUM_COLS - 1; c++)
         band_window[c] = '0;
      band_fill = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
   endtask

   // fill from reset without a start flag, then saturate every Laplacian
   task automatic test_checkerboard();
      column_type col;
      for (int c = 0; c < 7; c++) begin
         for (int r = 0; r < lfs_pkg::NUM_ROWS; r++)
            col[r] = ((r + c) % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
         send_column(1'b0, col);
      end
      send_column(1'b0, '0);
   endtask

   // restarts during fill and on a full window
   task automatic test_restart();
      for (int i = 0; i < 3; i++)
         send_column(i == 0, random_column());
      for (int i = 0; i < 6; i++)
         send_column(i == 0, random_column());
      for (int i = 0; i < 5; i++)
         send_column(i == 0, random_column());
      send_column(1'b0, {lfs_pkg::NUM_ROWS{32'hFFFF_FFFF}});
   endtask

   task automatic test_random_bands(input int n_cols, input int idle_pct, input int stall_pct);
      int sent;
      int run_len;
      bit first;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      sent = 0;
      while (sent < n_cols) begin
         // mostly full bands, some broken short ones
         run_len = ($urandom_range(99) < 15) ? $urandom_range(1, 4) : $urandom_range(5, 40);
         for (int i = 0; i < run_len && sent < n_cols; i++) begin
            if (i == 0)
               first = ($urandom_range(99) < 90);
            else
               first = ($urandom_range(99) < 3);
            send_column(first, random_column());
            sent++;
         end
      end
      req_tvalid <= 1'b0;
      while (pending_flux_q.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      apply_reset();
      test_checkerboard();
      test_restart();
      test_random_bands(100, 0, 0);
      test_random_bands(100, 87, 0);
      test_random_bands(100, 0, 87);
      test_random_bands(100, 11, 11);
      rsp_stall_pct = 0;
      while (pending_flux_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

### files.f
rtl/core/lfs_pkg.sv
rtl/core/laplacian_flux_stencil.sv
sim/tb.sv
